/* hdl/bhrc_pkg.sv */
package bhrc_pkg;

  // Width of the capacity register and its value after reset.
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 8;

  // Fixed field widths of the command and response words.
  localparam int FUNC_W    = 3;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 5;
  localparam int CURSOR_W  = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 3'd0,
    FUNC_BACK  = 3'd1,
    FUNC_FWD   = 3'd2,
    FUNC_CLEAR = 3'd3,
    FUNC_READ  = 3'd4
  } func_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] entry_value;
  } cmd_word_t;

  typedef struct packed {
    logic                accepted;
    logic                current_valid;
    logic [VALUE_W-1:0]  current_value;
    logic                previous_valid;
    logic [VALUE_W-1:0]  previous_value;
    logic [COUNT_W-1:0]  entry_count;
    logic [CURSOR_W-1:0] cursor_back;
  } rsp_word_t;

endpackage

/* hdl/bhrc_ram.sv */
module bhrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* hdl/bounded_history_ring_cursor.sv */
// Bounded history of entry handles with a cursor that counts back from the
// newest entry.
//
// The command channel (cmd_valid, cmd_stall, cmd) carries one word per
// operation: push, step back, step forward, clear or read. Every accepted
// command produces exactly one response word on the response channel
// (rsp_valid, rsp_stall, rsp) holding the accept flag, the entry under the
// cursor, the entry just older than it, the entry count and the cursor.
//
// A command updates the pointers and writes the entry store when accepted,
// and the store's registered read fetches the two entries; the read data
// then loads the response register on rsp. No new command is taken while
// one waits for its read data. A new command is taken while the previous
// response is still held, as long as that response leaves at the same edge.
//
// Reset (rst, synchronous) empties the history, returns the cursor to the
// newest entry and sets the capacity to eight. A stalled response stays put
// on rsp, and cmd_stall stays high until it is taken. The user must write
// the capacity register through cfg_we and cfg_data only while no command
// is in flight; the block itself does not enforce this.
module bounded_history_ring_cursor #(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  bhrc_pkg::cmd_word_t         cmd,
  input  logic                        cfg_we,
  input  logic [bhrc_pkg::CAP_W-1:0]  cfg_data,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output bhrc_pkg::rsp_word_t         rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Architectural state. The entries themselves live in the RAM; these
  // registers only describe where the live window of the ring sits.
  logic [bhrc_pkg::CAP_W-1:0] capacity;
  logic [AW-1:0]              oldest;
  logic [CW-1:0]              held;
  logic [AW-1:0]              back;

  logic [AW-1:0]              oldest_next;
  logic [CW-1:0]              held_next;
  logic [AW-1:0]              back_next;

  // Response fields that are known when a command is accepted wait here for
  // the read data to come back from the RAM.
  logic                       rd_pending;
  logic                       m_accepted;
  logic                       m_cur_ok;
  logic                       m_prev_ok;
  logic [CW-1:0]              m_held;
  logic [AW-1:0]              m_back;
  logic                       m_fwd;
  logic [ENTRY_WIDTH-1:0]     fwd_data;

  logic                       accept;
  logic                       ok;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [ENTRY_WIDTH-1:0]     wdata;
  logic [CW-1:0]              cap_eff;
  logic [CW-1:0]              h_tmp;
  logic [CW-1:0]              pos;
  logic                       cur_ok;
  logic                       prev_ok;
  logic [AW-1:0]              cur_addr;
  logic [AW-1:0]              prev_addr;
  logic [ENTRY_WIDTH-1:0]     rdata_cur;
  logic [ENTRY_WIDTH-1:0]     rdata_prev;
  logic [ENTRY_WIDTH-1:0]     cur_word;

  // Physical slot of a position counted from the oldest entry, modulo DEPTH.
  // Both operands are below DEPTH, so one conditional subtract is enough.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] offs);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, offs};
    if (s >= (AW + 1)'(DEPTH)) begin
      s = s - (AW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // A command is held off while the previous one still waits for its read
  // data, or while the response register is full and not draining.
  assign cmd_stall = rst | rd_pending | (rsp_valid & rsp_stall);
  assign accept    = cmd_valid & ~cmd_stall;
  assign wdata     = ENTRY_WIDTH'(cmd.entry_value);

  always_comb begin
    // Capacity beyond the store depth is clipped to the depth.
    if (int'(capacity) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(capacity);
    end

    oldest_next = oldest;
    held_next   = held;
    back_next   = back;
    ok          = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    h_tmp       = held;

    case (cmd.func)
      bhrc_pkg::FUNC_PUSH: begin
        if (cap_eff != '0) begin
          // Drop everything newer than the cursor entry first.
          h_tmp = held - CW'(back);
          // A full history evicts its oldest entry. After the capacity was
          // lowered without a clear, only one entry goes per push.
          if (h_tmp >= cap_eff && h_tmp != '0) begin
            oldest_next = slot_of(oldest, AW'(1));
            h_tmp       = h_tmp - CW'(1);
          end
          waddr     = slot_of(oldest_next, AW'(h_tmp));
          held_next = h_tmp + CW'(1);
          back_next = '0;
          we        = accept;
          ok        = 1'b1;
        end
      end
      bhrc_pkg::FUNC_BACK: begin
        if (CW'(back) + CW'(1) < held) begin
          back_next = back + AW'(1);
          ok        = 1'b1;
        end
      end
      bhrc_pkg::FUNC_FWD: begin
        if (back != '0) begin
          back_next = back - AW'(1);
          ok        = 1'b1;
        end
      end
      bhrc_pkg::FUNC_CLEAR: begin
        oldest_next = '0;
        held_next   = '0;
        back_next   = '0;
        ok          = 1'b1;
      end
      bhrc_pkg::FUNC_READ: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    // Cursor entry and the one just older than it, after the update. The
    // cursor is always below the count, so a nonzero count means an entry.
    pos       = held_next - CW'(1) - CW'(back_next);
    cur_ok    = (held_next != '0);
    prev_ok   = cur_ok && (pos != '0);
    cur_addr  = slot_of(oldest_next, AW'(pos));
    prev_addr = slot_of(oldest_next, AW'(pos - CW'(1)));
  end

  bhrc_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (accept),
    .raddr_a (cur_addr),
    .raddr_b (prev_addr),
    .rdata_a (rdata_cur),
    .rdata_b (rdata_prev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bhrc_pkg::CAP_W'(bhrc_pkg::CAP_RESET);
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest     <= '0;
      held       <= '0;
      back       <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= accept;
      if (accept) begin
        oldest <= oldest_next;
        held   <= held_next;
        back   <= back_next;
      end
    end
  end

  // After a push the cursor sits on the entry being written, and that write
  // lands in the same cycle as the read, so the new value is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_accepted <= ok;
      m_cur_ok   <= cur_ok;
      m_prev_ok  <= prev_ok;
      m_held     <= held_next;
      m_back     <= back_next;
      m_fwd      <= we;
      fwd_data   <= wdata;
    end
  end

  assign cur_word = m_fwd ? fwd_data : rdata_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rd_pending) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // The response register only loads when it is empty or draining, which
  // cmd_stall guarantees when the command is accepted.
  always_ff @(posedge clk) begin
    if (rd_pending) begin
      rsp.accepted       <= m_accepted;
      rsp.current_valid  <= m_cur_ok;
      rsp.current_value  <= m_cur_ok ? bhrc_pkg::VALUE_W'(cur_word) : '0;
      rsp.previous_valid <= m_prev_ok;
      rsp.previous_value <= m_prev_ok ? bhrc_pkg::VALUE_W'(rdata_prev) : '0;
      rsp.entry_count    <= bhrc_pkg::COUNT_W'(m_held);
      rsp.cursor_back    <= bhrc_pkg::CURSOR_W'(m_back);
    end
  end

endmodule

/* hdl/bhrc_checker.sv */
module bhrc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_stall,
  input bhrc_pkg::cmd_word_t        cmd,
  input logic                       cfg_we,
  input logic [bhrc_pkg::CAP_W-1:0] cfg_data,
  input logic                       rsp_valid,
  input logic                       rsp_stall,
  input bhrc_pkg::rsp_word_t        rsp
);

  // A stalled response word stays on the port unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  // Every accepted command is answered with a valid response word.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> ##1 rsp_valid)
    else $error("response missing two cycles after command");

  // A clear always succeeds and leaves an empty history.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && cmd.func == bhrc_pkg::FUNC_CLEAR
    |=> ##1 rsp.accepted && rsp.entry_count == '0 && rsp.cursor_back == '0
            && !rsp.current_valid)
    else $error("clear did not empty the history");

  // The cursor stays inside the held entries, and the flags agree with it.
  a_cursor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.entry_count == '0)
      ? (rsp.cursor_back == '0 && !rsp.current_valid && !rsp.previous_valid)
      : (rsp.current_valid && 5'(rsp.cursor_back) < rsp.entry_count))
    else $error("cursor outside the held entries");

  // Invalid entries read as zero, and an older entry implies a current one.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.current_valid || rsp.current_value == '0)
      && (rsp.previous_valid || rsp.previous_value == '0)
      && (!rsp.previous_valid || rsp.current_valid))
    else $error("inconsistent entry flags or values");

endmodule

bind bounded_history_ring_cursor bhrc_checker u_bhrc_checker (.*);

/* test/bounded_history_ring_cursor_tb.sv */
module bounded_history_ring_cursor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The history is built with its default geometry. The depth is a power of
  // two, so slot arithmetic below wraps by simple truncation.
  localparam int HIST_DEPTH = 16;
  localparam int SLOT_W = $clog2(HIST_DEPTH);
  localparam int BIT_SEL_W = $clog2(bhrc_pkg::VALUE_W);
  localparam int CAP_MAX = (1 << bhrc_pkg::CAP_W) - 1;
  localparam int FUNC_CODE_MAX = (1 << bhrc_pkg::FUNC_W) - 1;

  // A stretch of quiet, SETTLE_CYCLES long, is allowed before a capacity
  // write and before the final verdict.
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_COUNT = 16;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int MAX_REPORTS = 10;
  localparam int STALL_SPAN = 64;
  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  bhrc_pkg::cmd_word_t cmd = '0;
  logic cfg_we = 1'b0;
  logic [bhrc_pkg::CAP_W-1:0] cfg_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  bhrc_pkg::rsp_word_t rsp;

  // Shadow copy of the block's state. It is advanced once per accepted
  // command word, in the order the block takes them.
  logic [bhrc_pkg::VALUE_W-1:0] history_slots [HIST_DEPTH];
  logic [SLOT_W-1:0] oldest_slot_idx = '0;
  logic [bhrc_pkg::COUNT_W-1:0] held_entries = '0;
  logic [bhrc_pkg::CURSOR_W-1:0] steps_back = '0;
  logic [bhrc_pkg::CAP_W-1:0] capacity_setting = bhrc_pkg::CAP_W'(bhrc_pkg::CAP_RESET);

  // Response words that the shadow model says are still owed by the block.
  bhrc_pkg::rsp_word_t owed_responses [$];

  int mismatch_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int unsigned cycle_count = 0;
  stall_mode_t stall_mode = STALL_NONE;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bounded_history_ring_cursor #(
    .DEPTH      (HIST_DEPTH),
    .ENTRY_WIDTH(bhrc_pkg::VALUE_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // Applies one command to the shadow history and returns the response word
  // the block must produce for it. The effective capacity saturates at the
  // store depth, and a capacity of zero turns a push into a no-op.
  function automatic bhrc_pkg::rsp_word_t apply_history_cmd(
      input logic [bhrc_pkg::FUNC_W-1:0]  op,
      input logic [bhrc_pkg::VALUE_W-1:0] value);
    bhrc_pkg::rsp_word_t r;
    logic [bhrc_pkg::COUNT_W-1:0] limit;
    logic [bhrc_pkg::COUNT_W-1:0] pos;
    logic ok;
    r = '0;
    ok = 1'b0;
    limit = (capacity_setting > HIST_DEPTH) ? bhrc_pkg::COUNT_W'(HIST_DEPTH)
                                            : capacity_setting;
    case (op)
      bhrc_pkg::FUNC_PUSH: begin
        if (limit != 0) begin
          // Everything newer than the cursor entry is dropped first. When the
          // history is at or above the limit, exactly one oldest entry goes.
          held_entries = held_entries - bhrc_pkg::COUNT_W'(steps_back);
          steps_back = '0;
          if (held_entries >= limit) begin
            oldest_slot_idx = oldest_slot_idx + 1'b1;
            held_entries = held_entries - 1'b1;
          end
          history_slots[SLOT_W'(oldest_slot_idx + held_entries)] = value;
          held_entries = held_entries + 1'b1;
          ok = 1'b1;
        end
      end
      bhrc_pkg::FUNC_BACK: begin
        if (steps_back + 1 < held_entries) begin
          steps_back = steps_back + 1'b1;
          ok = 1'b1;
        end
      end
      bhrc_pkg::FUNC_FWD: begin
        if (steps_back != 0) begin
          steps_back = steps_back - 1'b1;
          ok = 1'b1;
        end
      end
      bhrc_pkg::FUNC_CLEAR: begin
        held_entries = '0;
        steps_back = '0;
        oldest_slot_idx = '0;
        ok = 1'b1;
      end
      bhrc_pkg::FUNC_READ: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    if (held_entries != 0) begin
      pos = held_entries - 1'b1 - bhrc_pkg::COUNT_W'(steps_back);
      r.current_valid = 1'b1;
      r.current_value = history_slots[SLOT_W'(oldest_slot_idx + pos)];
      if (pos != 0) begin
        r.previous_valid = 1'b1;
        r.previous_value = history_slots[SLOT_W'(oldest_slot_idx + pos - 1'b1)];
      end
    end
    r.accepted = ok;
    r.entry_count = held_entries;
    r.cursor_back = steps_back;
    return r;
  endfunction

  // Entry values lean toward the corners: all zeros, all ones, a single set
  // bit and a single clear bit, besides plain random words.
  function automatic logic [bhrc_pkg::VALUE_W-1:0] pick_entry_value();
    logic [bhrc_pkg::VALUE_W-1:0] one_hot;
    one_hot = '0;
    one_hot[BIT_SEL_W'($urandom_range(0, bhrc_pkg::VALUE_W - 1))] = 1'b1;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return $urandom();
    endcase
  endfunction

  // Picks a command code. The walking mix favors cursor moves so that long
  // excursions toward the oldest entry happen; the other mix favors pushes.
  // A small share goes to the codes the block does not define.
  function automatic logic [bhrc_pkg::FUNC_W-1:0] pick_op(input bit walking);
    int roll;
    roll = $urandom_range(0, 99);
    if (walking) begin
      if (roll < 20) return bhrc_pkg::FUNC_PUSH;
      if (roll < 60) return bhrc_pkg::FUNC_BACK;
      if (roll < 85) return bhrc_pkg::FUNC_FWD;
      if (roll < 88) return bhrc_pkg::FUNC_CLEAR;
      if (roll < 96) return bhrc_pkg::FUNC_READ;
    end else begin
      if (roll < 55) return bhrc_pkg::FUNC_PUSH;
      if (roll < 72) return bhrc_pkg::FUNC_BACK;
      if (roll < 84) return bhrc_pkg::FUNC_FWD;
      if (roll < 88) return bhrc_pkg::FUNC_CLEAR;
      if (roll < 96) return bhrc_pkg::FUNC_READ;
    end
    return bhrc_pkg::FUNC_W'($urandom_range(bhrc_pkg::FUNC_READ + 1, FUNC_CODE_MAX));
  endfunction

  // Presents one command word and holds it until the block takes it. The
  // caller is always at a rising edge on entry and is left at one on return.
  // Valid is only lowered when a gap starts, so it never drops and rises
  // within the same edge. Bursts are mostly short, now and then long enough
  // to keep the block busy with no idling at all.
  task automatic send_cmd(input logic [bhrc_pkg::FUNC_W-1:0] op,
                          input logic [bhrc_pkg::VALUE_W-1:0] value);
    bhrc_pkg::cmd_word_t word;
    word.func = op;
    word.entry_value = value;
    cmd_valid <= 1'b1;
    cmd <= word;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    owed_responses.push_back(apply_history_cmd(op, value));
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Stops sending, waits for every owed response, then lets the pipeline go
  // quiet so that a capacity write cannot land under a command in flight.
  task automatic wait_for_idle();
    cmd_valid <= 1'b0;
    while (owed_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [bhrc_pkg::CAP_W-1:0] value);
    wait_for_idle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_setting = value;
  endtask

  // An empty history: reads and both cursor moves must report nothing held,
  // and the undefined codes must do nothing at all.
  task automatic test_empty_history();
    send_cmd(bhrc_pkg::FUNC_READ, $urandom());
    send_cmd(bhrc_pkg::FUNC_BACK, $urandom());
    send_cmd(bhrc_pkg::FUNC_FWD, $urandom());
    for (int code = bhrc_pkg::FUNC_READ + 1; code <= FUNC_CODE_MAX; code++) begin
      send_cmd(bhrc_pkg::FUNC_W'(code), $urandom());
    end
  endtask

  // Fills a four-entry history with the corner values and pushes once more,
  // so the oldest entry is evicted.
  task automatic test_fill_and_evict();
    write_capacity(bhrc_pkg::CAP_W'(4));
    send_cmd(bhrc_pkg::FUNC_PUSH, '0);
    send_cmd(bhrc_pkg::FUNC_PUSH, '1);
    send_cmd(bhrc_pkg::FUNC_PUSH, 32'h5555_5555);
    send_cmd(bhrc_pkg::FUNC_PUSH, 32'hAAAA_AAAA);
    send_cmd(bhrc_pkg::FUNC_PUSH, $urandom());
  endtask

  // Walks the cursor back to the oldest entry and one step beyond it, then
  // forward, then pushes from the middle so the entries ahead are discarded.
  // A forward step at the newest entry must fail.
  task automatic test_cursor_walk();
    repeat (4) send_cmd(bhrc_pkg::FUNC_BACK, $urandom());
    send_cmd(bhrc_pkg::FUNC_FWD, $urandom());
    send_cmd(bhrc_pkg::FUNC_PUSH, $urandom());
    send_cmd(bhrc_pkg::FUNC_FWD, $urandom());
    send_cmd(bhrc_pkg::FUNC_CLEAR, $urandom());
  endtask

  // Lowers the capacity below the count without a clear, so a push evicts a
  // single entry and the count holds. Then a zero capacity drops a push, and
  // the largest register value saturates at the store depth.
  task automatic test_capacity_limits();
    repeat (3) send_cmd(bhrc_pkg::FUNC_PUSH, pick_entry_value());
    write_capacity(bhrc_pkg::CAP_W'(1));
    send_cmd(bhrc_pkg::FUNC_PUSH, pick_entry_value());
    write_capacity('0);
    send_cmd(bhrc_pkg::FUNC_PUSH, pick_entry_value());
    write_capacity(bhrc_pkg::CAP_W'(CAP_MAX));
    send_cmd(bhrc_pkg::FUNC_CLEAR, $urandom());
  endtask

  // Random phases, each with its own capacity. The first phases take the
  // register's extremes and the values around the store depth. One phase in
  // three runs well-formed fill-then-walk sequences, which is what drives the
  // count to the full depth and the cursor to its deepest position; the rest
  // use weighted random commands. Most phases clear after the capacity write,
  // a few keep the old contents to hit the lowered-capacity path.
  task automatic test_random_history();
    int cap_choices [8];
    int phase_end;
    int fill_len;
    cap_choices = '{bhrc_pkg::CAP_RESET, HIST_DEPTH, CAP_MAX, 0, 1, 2, HIST_DEPTH + 1, 3};
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase < 8) write_capacity(bhrc_pkg::CAP_W'(cap_choices[phase]));
      else write_capacity(bhrc_pkg::CAP_W'($urandom_range(0, CAP_MAX)));
      if ($urandom_range(0, 3) != 0) send_cmd(bhrc_pkg::FUNC_CLEAR, $urandom());
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        if (phase % 3 == 1) begin
          fill_len = $urandom_range(1, HIST_DEPTH + 2);
          repeat (fill_len) send_cmd(bhrc_pkg::FUNC_PUSH, pick_entry_value());
          repeat ($urandom_range(fill_len - 1, fill_len + 1)) begin
            send_cmd(bhrc_pkg::FUNC_BACK, $urandom());
          end
          repeat ($urandom_range(0, fill_len)) send_cmd(bhrc_pkg::FUNC_FWD, $urandom());
          if ($urandom_range(0, 1) != 0) send_cmd(bhrc_pkg::FUNC_PUSH, pick_entry_value());
        end else begin
          send_cmd(pick_op(phase % 3 == 2), pick_entry_value());
        end
      end
    end
  endtask

  // Response checker. Every word taken from the block is matched against the
  // oldest owed word, field by field. A word with nothing owed is an error.
  always @(posedge clk) begin
    bhrc_pkg::rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: response word %h arrived with nothing owed", $realtime, rsp);
        end
      end else begin
        want = owed_responses.pop_front();
        if (rsp.accepted !== want.accepted || rsp.current_valid !== want.current_valid ||
            rsp.current_value !== want.current_value ||
            rsp.previous_valid !== want.previous_valid ||
            rsp.previous_value !== want.previous_value ||
            rsp.entry_count !== want.entry_count || rsp.cursor_back !== want.cursor_back) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch accepted %0b/%0b current %0b:%h/%0b:%h", $realtime,
                     want.accepted, rsp.accepted, want.current_valid, want.current_value,
                     rsp.current_valid, rsp.current_value);
            $display("  previous %0b:%h/%0b:%h count %0d/%0d cursor %0d/%0d (expected/actual)",
                     want.previous_valid, want.previous_value, rsp.previous_valid,
                     rsp.previous_value, want.entry_count, rsp.entry_count,
                     want.cursor_back, rsp.cursor_back);
          end
        end
      end
    end
  end

  // Cycle count, response backpressure and the run limit. The stall pattern is
  // picked anew once per STALL_SPAN from none, light, heavy and a fixed period,
  // so gaps land on every phase of the block's accept-then-read rhythm.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % STALL_SPAN == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
    end
    case (stall_mode)
      STALL_NONE: rsp_stall <= 1'b0;
      STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
      default: rsp_stall <= ((cycle_count % 7) < 3);
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bounded_history_ring_cursor regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_history();
    test_fill_and_evict();
    test_cursor_walk();
    test_capacity_limits();
    test_random_history();
    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && owed_responses.size() == 0) begin
      $display("bounded_history_ring_cursor regression: pass");
    end else begin
      $display("bounded_history_ring_cursor regression: fail");
    end
    $finish;
  end

endmodule

/* bounded_history_ring_cursor.f */
hdl/bhrc_pkg.sv
hdl/bhrc_ram.sv
hdl/bounded_history_ring_cursor.sv
hdl/bhrc_checker.sv
test/bounded_history_ring_cursor_tb.sv
